// File: rtl/rsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
`default_nettype none

package rsc_pkg;

  // Default number of stack entries
  localparam int unsigned STACK_DEPTH = 64;

  // Word width of the stack and of the operands
  localparam int unsigned DATA_W = 32;

  // Width of the reported entry count
  localparam int unsigned COUNT_W = 7;

  // Value returned by a pop from an empty stack
  localparam logic [DATA_W-1:0] EMPTY_POP_VALUE = 32'h8000_0000;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_MUL  = 3'd2,
    OP_SUB  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5
  } opcode_e;

  // Per-cell move command
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_TAKE_UP   = 2'd1,
    CELL_TAKE_DOWN = 2'd2
  } cell_cmd_e;

  // Input item
  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [COUNT_W-1:0]       stack_count;
    logic                     underflow;
    logic                     overflow;
    logic                     divide_by_zero;
  } out_item_t;

  // Divider control from the sequencer
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/rsc_cell.sv
// One stack entry: holds a word or takes it from a neighbor.
`default_nettype none

module rsc_cell (
  input  wire logic                         clk_i,
  input  wire rsc_pkg::cell_cmd_e           cmd_i,
  input  wire logic [rsc_pkg::DATA_W-1:0]   up_i,
  input  wire logic [rsc_pkg::DATA_W-1:0]   down_i,
  output logic      [rsc_pkg::DATA_W-1:0]   data_o
);

  logic [rsc_pkg::DATA_W-1:0] data_q;
  logic [rsc_pkg::DATA_W-1:0] data_d;

  // Select the next word from the command
  always_comb begin
    case (cmd_i)
      rsc_pkg::CELL_TAKE_UP:   data_d = up_i;
      rsc_pkg::CELL_TAKE_DOWN: data_d = down_i;
      default:                 data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/rsc_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rsc_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rsc_pkg::div_ctrl_t           ctrl_i,
  input  wire logic [rsc_pkg::DATA_W-1:0]   dividend_i,
  input  wire logic [rsc_pkg::DATA_W-1:0]   divisor_i,
  output rsc_pkg::div_stat_t                stat_o,
  output logic      [rsc_pkg::DATA_W-1:0]   quotient_o
);

  localparam int unsigned DW    = rsc_pkg::DATA_W;
  localparam int unsigned IterW = $clog2(DW);

  logic             busy_q;
  logic [IterW-1:0] iter_q;
  logic             neg_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    quo_q;
  logic [DW-1:0]    dvs_q;
  logic [DW:0]      trial;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, quo_q[DW-1]} - {1'b0, dvs_q};

  // Advance control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      iter_q <= IterW'(DW - 1);
    end else if (busy_q) begin
      iter_q <= iter_q - IterW'(1);
      if (iter_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Load magnitudes, then shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      neg_q <= dividend_i[DW-1] ^ divisor_i[DW-1];
      rem_q <= '0;
      quo_q <= dividend_i[DW-1] ? (DW'(0) - dividend_i) : dividend_i;
      dvs_q <= divisor_i[DW-1] ? (DW'(0) - divisor_i) : divisor_i;
    end else if (busy_q) begin
      if (!trial[DW]) begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DW-2:0], quo_q[DW-1]};
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

  assign quotient_o  = neg_q ? (DW'(0) - quo_q) : quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = !busy_q;

endmodule

`default_nettype wire

// File: rtl/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: sequencer, stack cells and divider.
//
// Usage:
//   Input channel in_valid_i/in_ready_o carries one opcode item with its
//   push value. Output channel out_valid_o/out_ready_i returns exactly one
//   result item per input item, in order: the pushed, popped or computed value, the
//   entry count after the item and the underflow, overflow and
//   divide-by-zero flags.
//   Push, pop, add, subtract, multiply, divide by zero and unused codes
//   raise out_valid_o when they commit from S_EXEC, once the output
//   register is free; divide with a nonzero divisor first runs the 32-step
//   shift-subtract divider in S_DIV. New items are taken only in S_IDLE.
//   The stack is a row of cells that shift toward or away from the top.
//   The next item is taken while a finished result still waits in the
//   output register; its own result waits for that register to empty.
//   Reset empties the stack (count zero) and drops any pending result.
//   When the receiver stalls, the result holds and the block stops after
//   accepting at most one further item.
`default_nettype none

module rpn_stack_calculator #(
  parameter int unsigned StackDepth = rsc_pkg::STACK_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire rsc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rsc_pkg::out_item_t      out_item_o
);

  localparam int unsigned DW   = rsc_pkg::DATA_W;
  localparam int unsigned CntW = $clog2(StackDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DIV  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [2:0]         op_q;
  logic [DW-1:0]      val_q;
  logic               out_valid_q;
  rsc_pkg::out_item_t out_q;

  logic [DW-1:0]      cell_data [StackDepth];
  rsc_pkg::cell_cmd_e cmd_top, cmd_rest;
  logic [DW-1:0]      new_word;

  rsc_pkg::div_ctrl_t div_ctrl;
  rsc_pkg::div_stat_t div_stat;
  logic [DW-1:0]      div_quo;

  logic               slot_free;
  logic               commit;
  logic               cnt_zero, cnt_lt2, full;
  logic [DW-1:0]      opa, opb;
  logic [DW-1:0]      result;
  logic               uflow, oflow, dzero;

  // Stack cells, top entry first
  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    logic [DW-1:0] up_w, down_w;
    rsc_pkg::cell_cmd_e cmd_w;
    if (i == 0) begin : g_top
      assign up_w  = new_word;
      assign cmd_w = cmd_top;
    end else begin : g_mid
      assign up_w  = cell_data[i-1];
      assign cmd_w = cmd_rest;
    end
    if (i == StackDepth - 1) begin : g_bot
      assign down_w = '0;
    end else begin : g_inner
      assign down_w = cell_data[i+1];
    end
    rsc_cell u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_w),
      .up_i   (up_w),
      .down_i (down_w),
      .data_o (cell_data[i])
    );
  end

  // Operands as the two pops would see them
  assign cnt_zero = (cnt_q == '0);
  assign cnt_lt2  = (cnt_q < CntW'(2));
  assign full     = (cnt_q >= CntW'(StackDepth));
  assign opa      = cnt_zero ? rsc_pkg::EMPTY_POP_VALUE : cell_data[0];
  assign opb      = cnt_lt2  ? rsc_pkg::EMPTY_POP_VALUE : cell_data[1];

  assign div_ctrl.start = (state_q == S_EXEC) && (op_q == rsc_pkg::OP_DIV) && (opa != '0);

  rsc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (opb),
    .divisor_i  (opa),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  // Result, flags and stack moves for the item in hand
  always_comb begin
    result   = '0;
    uflow    = 1'b0;
    oflow    = 1'b0;
    dzero    = 1'b0;
    cmd_top  = rsc_pkg::CELL_HOLD;
    cmd_rest = rsc_pkg::CELL_HOLD;
    cnt_d    = cnt_q;
    case (op_q)
      rsc_pkg::OP_PUSH: begin
        result = val_q;
        if (full) begin
          oflow = 1'b1;
        end else begin
          cmd_top  = rsc_pkg::CELL_TAKE_UP;
          cmd_rest = rsc_pkg::CELL_TAKE_UP;
          cnt_d    = cnt_q + CntW'(1);
        end
      end
      rsc_pkg::OP_ADD, rsc_pkg::OP_MUL, rsc_pkg::OP_SUB, rsc_pkg::OP_DIV: begin
        case (op_q)
          rsc_pkg::OP_ADD: result = opa + opb;
          rsc_pkg::OP_MUL: result = DW'(opa * opb);
          rsc_pkg::OP_SUB: result = opb - opa;
          default: begin
            if (opa == '0) begin
              dzero = 1'b1;
            end else begin
              result = div_quo;
            end
          end
        endcase
        uflow   = cnt_lt2;
        cmd_top = rsc_pkg::CELL_TAKE_UP;
        if (cnt_lt2) begin
          cnt_d = CntW'(1);
        end else begin
          cmd_rest = rsc_pkg::CELL_TAKE_DOWN;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      rsc_pkg::OP_POP: begin
        if (cnt_zero) begin
          uflow  = 1'b1;
          result = rsc_pkg::EMPTY_POP_VALUE;
        end else begin
          result   = cell_data[0];
          cmd_top  = rsc_pkg::CELL_TAKE_DOWN;
          cmd_rest = rsc_pkg::CELL_TAKE_DOWN;
          cnt_d    = cnt_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
    // Stack moves only when the result is written out
    if (!commit) begin
      cmd_top  = rsc_pkg::CELL_HOLD;
      cmd_rest = rsc_pkg::CELL_HOLD;
      cnt_d    = cnt_q;
    end
  end

  assign new_word = (op_q == rsc_pkg::OP_PUSH) ? val_q : result;

  // Sequencer
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    commit  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (div_ctrl.start) begin
          state_d = S_DIV;
        end else if (slot_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done && slot_free) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the item and the result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= in_item_i.opcode;
      val_q <= in_item_i.operand_value;
    end
    if (commit) begin
      out_q.top_value      <= result;
      out_q.stack_count    <= rsc_pkg::COUNT_W'(cnt_d);
      out_q.underflow      <= uflow;
      out_q.overflow       <= oflow;
      out_q.divide_by_zero <= dzero;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth))
    else $error("stack count beyond depth");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_div_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && op_q == rsc_pkg::OP_PUSH && !full) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("push did not grow the stack");
`endif

endmodule

`default_nettype wire
